>>> src/meg_pkg.sv
// Shared constants and types for the mesh element geometry block.
// No dependencies; every other file imports this package.
package meg_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 15;

  localparam int FIELD_W = 24;
  localparam int OP_W    = 2;
  localparam int MEAS_W  = 50;
  localparam int DIR_W   = 16;

  localparam logic [31:0] DIR_MAX = 32'd32767;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE     = 2'd0,
    OP_SEGMENT  = 2'd1,
    OP_TRIANGLE = 2'd2
  } op_t;

endpackage

>>> src/meg_in_if.sv
// Input channel of the mesh element geometry block: opcode and node coordinates.
// Depends on meg_pkg.
interface meg_in_if import meg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic signed [FIELD_W-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;

  modport source(output valid, opcode, x0, y0, z0, x1, y1, z1, x2, y2, z2, input ready);
  modport sink(input valid, opcode, x0, y0, z0, x1, y1, z1, x2, y2, z2, output ready);
endinterface

>>> src/meg_out_if.sv
// Result channel of the mesh element geometry block: measure and unit direction.
// Depends on meg_pkg.
interface meg_out_if import meg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [MEAS_W-1:0]       measure;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  logic                    dir_valid;

  modport source(output valid, measure, dir_x, dir_y, dir_z, dir_valid, input ready);
  modport sink(input valid, measure, dir_x, dir_y, dir_z, dir_valid, output ready);
endinterface

>>> src/mesh_element_geometry.sv
// Mesh element geometry: edge length, segment length, triangle twice-area and unit direction.
// Depends on meg_pkg, meg_in_if, meg_out_if, meg_front, meg_sqrt_cell and meg_div_cell.
//
//   channel  modport  word
//   req      sink     opcode, x0..z2 (node coordinates)
//   rsp      source   measure, dir_x, dir_y, dir_z, dir_valid
//
// One word per cycle sustained while rsp is ready; the path is 7 front stages, one root cell
// per measure bit (2*COORD_BITS+2, 50 by default), FRAC_BITS+1 divider cells and the output
// register. Each stage moves when it is empty or its successor moves, so bubbles close up
// under a stall on rsp. Reset (rst, synchronous) clears only valid bits.
module mesh_element_geometry import meg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  meg_in_if.sink    req,
  meg_out_if.source rsp
);

  localparam int DW   = COORD_BITS + 1;
  localparam int MW   = 2 * DW - 1;
  localparam int RW   = MW + 1;
  localparam int NW   = 2 * MW + 2;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NUMW = MW + FRAC_BITS;
  localparam int SSW  = 3 * MW + 4;
  localparam int DSW  = 4;

  logic [8:0][FIELD_W-1:0] coords;
  assign coords = {req.z2, req.y2, req.x2, req.z1, req.y1, req.x1, req.z0, req.y0, req.x0};

  logic               f_valid, f_ready, f_dirs;
  logic [NW-1:0]      f_norm;
  logic [2:0][MW-1:0] f_mag;
  logic [2:0]         f_sign;

  meg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .opcode    (req.opcode),
    .coords    (coords),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_norm  (f_norm),
    .out_mag   (f_mag),
    .out_sign  (f_sign),
    .out_dirs  (f_dirs)
  );

  // Root chain.
  logic [RW:0]           sv, sr;
  logic [RW:0][RW+1:0]   srem;
  logic [RW:0][RW-1:0]   sroot;
  logic [RW:0][NW-1:0]   srad;
  logic [RW:0][SSW-1:0]  sside;

  assign sv[0]    = f_valid;
  assign f_ready  = sr[0];
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = f_norm;
  assign sside[0] = {f_dirs, f_sign, f_mag};

  genvar i;
  generate
    for (i = 0; i < RW; i++) begin : g_sqrt
      meg_sqrt_cell #(.RW(RW), .NW(NW), .SW(SSW)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (sv[i]),
        .in_ready  (sr[i]),
        .rem_in    (srem[i]),
        .root_in   (sroot[i]),
        .rad_in    (srad[i]),
        .side_in   (sside[i]),
        .out_valid (sv[i+1]),
        .out_ready (sr[i+1]),
        .rem_out   (srem[i+1]),
        .root_out  (sroot[i+1]),
        .rad_out   (srad[i+1]),
        .side_out  (sside[i+1])
      );
    end
  endgenerate

  // Divider chain; quotient bits from the top down.
  logic [QW:0]                 dv, dr;
  logic [QW:0][2:0][NUMW-1:0]  drem;
  logic [QW:0][2:0][QW-1:0]    dq;
  logic [QW:0][RW-1:0]         dlen;
  logic [QW:0][DSW-1:0]        dside;
  logic [2:0][MW-1:0]          r_mag;

  assign r_mag = sside[RW][3*MW-1:0];
  assign dv[0] = sv[RW];
  assign sr[RW] = dr[0];
  assign dlen[0] = sroot[RW];
  assign dside[0] = sside[RW][SSW-1:3*MW];
  assign dq[0] = '0;

  generate
    for (i = 0; i < 3; i++) begin : g_num
      assign drem[0][i] = {r_mag[i], {FRAC_BITS{1'b0}}};
    end
    for (i = 0; i < QW; i++) begin : g_div
      meg_div_cell #(
        .NUMW(NUMW), .RW(RW), .QW(QW), .SW(DSW), .BIT(QW - 1 - i)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (dv[i]),
        .in_ready  (dr[i]),
        .rem_in    (drem[i]),
        .q_in      (dq[i]),
        .len_in    (dlen[i]),
        .side_in   (dside[i]),
        .out_valid (dv[i+1]),
        .out_ready (dr[i+1]),
        .rem_out   (drem[i+1]),
        .q_out     (dq[i+1]),
        .len_out   (dlen[i+1]),
        .side_out  (dside[i+1])
      );
    end
  endgenerate

  // Output register: saturate, apply sign, blank directions for zero length, segments or the unused opcode.
  logic                    o_ready, dvalid_c;
  logic [31:0]             q32 [3];
  logic [DIR_W-1:0]        qmag [3];
  logic [2:0][DIR_W-1:0]   dir_c;

  assign o_ready  = ~rsp.valid | rsp.ready;
  assign dr[QW]   = o_ready;
  assign dvalid_c = dside[QW][DSW-1] & (dlen[QW] != '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q32[k]  = 32'(dq[QW][k]);
      qmag[k] = (q32[k] >= DIR_MAX) ? DIR_MAX[DIR_W-1:0] : q32[k][DIR_W-1:0];
      if (!dvalid_c) begin
        dir_c[k] = '0;
      end else if (dside[QW][k]) begin
        dir_c[k] = DIR_W'(-qmag[k]);
      end else begin
        dir_c[k] = qmag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (o_ready) begin
      rsp.valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      rsp.measure   <= MEAS_W'(dlen[QW]);
      rsp.dir_x     <= dir_c[0];
      rsp.dir_y     <= dir_c[1];
      rsp.dir_z     <= dir_c[2];
      rsp.dir_valid <= dvalid_c;
    end
  end

endmodule

>>> src/meg_front.sv
// Front pipeline: node differences, cross product, magnitudes and the squared norm.
// Depends on meg_pkg. Seven registered stages, each stalls only when full and blocked.
module meg_front import meg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OP_W-1:0]             opcode,
  input  logic [8:0][FIELD_W-1:0]     coords,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2*(2*(COORD_BITS+1)-1)+1:0] out_norm,
  output logic [2:0][2*(COORD_BITS+1)-2:0]  out_mag,
  output logic [2:0]                  out_sign,
  output logic                        out_dirs
);

  localparam int DW = COORD_BITS + 1;
  localparam int VW = 2 * DW;
  localparam int MW = VW - 1;
  localparam int NW = 2 * MW + 2;
  localparam int LW = (MW + 1) / 2;
  localparam int HW = MW - LW;
  localparam int NSTG = 7;

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] rdy;

  assign rdy[NSTG+1] = out_ready;
  assign in_ready    = rdy[1];
  assign out_valid   = vld[NSTG];

  genvar g;
  generate
    for (g = 1; g <= NSTG; g++) begin : g_ctl
      assign rdy[g] = ~vld[g] | rdy[g+1];
      if (g == 1) begin : g_head
        always_ff @(posedge clk) begin
          if (rst) begin
            vld[g] <= 1'b0;
          end else if (rdy[g]) begin
            vld[g] <= in_valid;
          end
        end
      end else begin : g_body
        always_ff @(posedge clk) begin
          if (rst) begin
            vld[g] <= 1'b0;
          end else if (rdy[g]) begin
            vld[g] <= vld[g-1];
          end
        end
      end
    end
  endgenerate

  // Stage 1: sign-extended coordinates and the edge vectors; b is set only for triangles.
  logic signed [DW-1:0] cs [9];
  logic signed [DW-1:0] a_c [3];
  logic signed [DW-1:0] b_c [3];
  logic                 tri_c, dirs_c;

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      cs[j] = DW'(signed'(coords[j][COORD_BITS-1:0]));
    end
    for (int k = 0; k < 3; k++) begin
      a_c[k] = '0;
      b_c[k] = '0;
    end
    tri_c  = 1'b0;
    dirs_c = 1'b0;
    case (opcode)
      OP_EDGE: begin
        for (int k = 0; k < 3; k++) a_c[k] = cs[k] - cs[3+k];
        dirs_c = 1'b1;
      end
      OP_SEGMENT: begin
        for (int k = 0; k < 2; k++) a_c[k] = cs[k] - cs[3+k];
      end
      OP_TRIANGLE: begin
        for (int k = 0; k < 3; k++) begin
          a_c[k] = cs[3+k] - cs[k];
          b_c[k] = cs[6+k] - cs[k];
        end
        tri_c  = 1'b1;
        dirs_c = 1'b1;
      end
      default: begin
        tri_c = 1'b0;
      end
    endcase
  end

  logic signed [DW-1:0] s1_a [3];
  logic signed [DW-1:0] s1_b [3];
  logic                 s1_tri, s1_dirs;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_a    <= a_c;
      s1_b    <= b_c;
      s1_tri  <= tri_c;
      s1_dirs <= dirs_c;
    end
  end

  // Stage 2: the six cross-product terms.
  logic signed [VW-1:0] s2_p [6];
  logic signed [DW-1:0] s2_a [3];
  logic                 s2_tri, s2_dirs;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_p[0] <= s1_a[1] * s1_b[2];
      s2_p[1] <= s1_a[2] * s1_b[1];
      s2_p[2] <= s1_a[2] * s1_b[0];
      s2_p[3] <= s1_a[0] * s1_b[2];
      s2_p[4] <= s1_a[0] * s1_b[1];
      s2_p[5] <= s1_a[1] * s1_b[0];
      s2_a    <= s1_a;
      s2_tri  <= s1_tri;
      s2_dirs <= s1_dirs;
    end
  end

  // Stage 3: the element vector, either the cross product or the edge itself.
  logic signed [VW-1:0] s3_v [3];
  logic                 s3_dirs;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        s3_v[k] <= s2_tri ? (s2_p[2*k] - s2_p[2*k+1]) : VW'(s2_a[k]);
      end
      s3_dirs <= s2_dirs;
    end
  end

  // Stage 4: magnitude and sign of each component.
  logic [VW-1:0]        neg_v [3];
  logic [2:0][MW-1:0]   s4_mag;
  logic [2:0]           s4_sign;
  logic                 s4_dirs;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_v[k] = s3_v[k][VW-1] ? VW'(-s3_v[k]) : VW'(s3_v[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int k = 0; k < 3; k++) begin
        s4_mag[k]  <= neg_v[k][MW-1:0];
        s4_sign[k] <= s3_v[k][VW-1];
      end
      s4_dirs <= s3_dirs;
    end
  end

  // Stage 5: each square split into three narrow partial products.
  logic [2*HW-1:0]    s5_hh [3];
  logic [MW-1:0]      s5_hl [3];
  logic [2*LW-1:0]    s5_ll [3];
  logic [2:0][MW-1:0] s5_mag;
  logic [2:0]         s5_sign;
  logic               s5_dirs;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int k = 0; k < 3; k++) begin
        s5_hh[k] <= s4_mag[k][MW-1:LW] * s4_mag[k][MW-1:LW];
        s5_hl[k] <= s4_mag[k][MW-1:LW] * s4_mag[k][LW-1:0];
        s5_ll[k] <= s4_mag[k][LW-1:0] * s4_mag[k][LW-1:0];
      end
      s5_mag  <= s4_mag;
      s5_sign <= s4_sign;
      s5_dirs <= s4_dirs;
    end
  end

  // Stage 6: squares assembled from the partial products.
  logic [NW-1:0]      s6_sq [3];
  logic [2:0][MW-1:0] s6_mag;
  logic [2:0]         s6_sign;
  logic               s6_dirs;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int k = 0; k < 3; k++) begin
        s6_sq[k] <= (NW'(s5_hh[k]) << (2 * LW)) + (NW'(s5_hl[k]) << (LW + 1))
                  + NW'(s5_ll[k]);
      end
      s6_mag  <= s5_mag;
      s6_sign <= s5_sign;
      s6_dirs <= s5_dirs;
    end
  end

  // Stage 7: the squared norm.
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      out_norm <= s6_sq[0] + s6_sq[1] + s6_sq[2];
      out_mag  <= s6_mag;
      out_sign <= s6_sign;
      out_dirs <= s6_dirs;
    end
  end

endmodule

>>> src/meg_sqrt_cell.sv
// One cell of the floor square root chain: settles one root bit per cell.
// Depends on meg_pkg; side data rides along unchanged.
module meg_sqrt_cell import meg_pkg::*; #(
  parameter int RW = MEAS_W,
  parameter int NW = 2 * MEAS_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [RW+1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  logic [NW-1:0] rad_in,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [RW+1:0] rem_out,
  output logic [RW-1:0] root_out,
  output logic [NW-1:0] rad_out,
  output logic [SW-1:0] side_out
);

  logic [RW+3:0] cur, trial, diff;
  logic          ge;

  always_comb begin
    cur   = {rem_in, rad_in[NW-1:NW-2]};
    trial = (RW+4)'({root_in, 2'b01});
    ge    = cur >= trial;
    diff  = cur - trial;
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_out  <= ge ? diff[RW+1:0] : cur[RW+1:0];
      root_out <= {root_in[RW-2:0], ge};
      rad_out  <= {rad_in[NW-3:0], 2'b00};
      side_out <= side_in;
    end
  end

endmodule

>>> src/meg_div_cell.sv
// One cell of the direction divider chain: one quotient bit for all three lanes.
// Depends on meg_pkg; the divisor and side data ride along unchanged.
module meg_div_cell import meg_pkg::*; #(
  parameter int NUMW = 64,
  parameter int RW   = MEAS_W,
  parameter int QW   = 16,
  parameter int SW   = 1,
  parameter int BIT  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0][NUMW-1:0] rem_in,
  input  logic [2:0][QW-1:0]   q_in,
  input  logic [RW-1:0]        len_in,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0][NUMW-1:0] rem_out,
  output logic [2:0][QW-1:0]   q_out,
  output logic [RW-1:0]        len_out,
  output logic [SW-1:0]        side_out
);

  logic [NUMW-1:0]      len_w;
  logic [2:0]           ge;
  logic [2:0][NUMW-1:0] rem_c;
  logic [2:0][QW-1:0]   q_c;

  always_comb begin
    len_w = NUMW'(len_in);
    for (int k = 0; k < 3; k++) begin
      ge[k]       = (rem_in[k] >> BIT) >= len_w;
      rem_c[k]    = ge[k] ? rem_in[k] - (len_w << BIT) : rem_in[k];
      q_c[k]      = q_in[k];
      q_c[k][BIT] = ge[k];
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_out  <= rem_c;
      q_out    <= q_c;
      len_out  <= len_in;
      side_out <= side_in;
    end
  end

endmodule

>>> verif/geometry_checker.sv
// Checker for the mesh element geometry block: watches the req and rsp channels,
// predicts each result word in order and compares it field by field. Depends on meg_pkg,
// meg_in_if and meg_out_if.
module geometry_checker import meg_pkg::*; (
  input  logic clk,
  input  logic rst,
  meg_in_if    req,
  meg_out_if   rsp,
  output int   errors,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MEAS_W-1:0]       measure;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    dir_valid;
  } geom_t;

  geom_t geom_q[$];

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [127:0] square_sum(logic signed [63:0] a, logic signed [63:0] b,
                                              logic signed [63:0] c);
    logic [127:0] ma, mb, mc;
    ma = {64'd0, abs64(a)};
    mb = {64'd0, abs64(b)};
    mc = {64'd0, abs64(c)};
    return ma * ma + mb * mb + mc * mc;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  r;
    logic [127:0] c;
    r = 0;
    for (int b = 50; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= n) r = c[63:0];
    end
    return r;
  endfunction

  // Truncated quotient of |d| * 2^15 over the length, saturated, then signed.
  function automatic logic [DIR_W-1:0] unit_comp(logic signed [63:0] d, logic [63:0] len);
    logic [127:0] num, l, c;
    logic [63:0]  q;
    num = {64'd0, abs64(d)} << FRAC_BITS_DEF;
    l = {64'd0, len};
    q = 0;
    if ({96'd0, DIR_MAX} * l <= num) begin
      q = {32'd0, DIR_MAX};
    end else begin
      for (int b = 14; b >= 0; b--) begin
        c = {64'd0, q | (64'd1 << b)};
        if (c * l <= num) q = c[63:0];
      end
    end
    if (d < 0) q = -q;
    return q[DIR_W-1:0];
  endfunction

  function automatic geom_t predict_geometry(logic [OP_W-1:0] op,
      logic signed [FIELD_W-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2);
    logic signed [63:0] vx, vy, vz, ax, ay, az, bx, by, bz;
    logic [63:0] len;
    logic        dirs;
    geom_t       g;
    vx = 0; vy = 0; vz = 0; len = 0; dirs = 0;
    case (op)
      OP_EDGE: begin
        vx = 64'(x0) - 64'(x1);
        vy = 64'(y0) - 64'(y1);
        vz = 64'(z0) - 64'(z1);
        len = floor_root(square_sum(vx, vy, vz));
        dirs = 1;
      end
      OP_SEGMENT: begin
        len = floor_root(square_sum(64'(x0) - 64'(x1), 64'(y0) - 64'(y1), 64'sd0));
      end
      OP_TRIANGLE: begin
        ax = 64'(x1) - 64'(x0); ay = 64'(y1) - 64'(y0); az = 64'(z1) - 64'(z0);
        bx = 64'(x2) - 64'(x0); by = 64'(y2) - 64'(y0); bz = 64'(z2) - 64'(z0);
        vx = ay * bz - az * by;
        vy = az * bx - ax * bz;
        vz = ax * by - ay * bx;
        len = floor_root(square_sum(vx, vy, vz));
        dirs = 1;
      end
      default: ;
    endcase
    g.measure = len[MEAS_W-1:0];
    if (dirs && len != 0) begin
      g.dir_x = unit_comp(vx, len);
      g.dir_y = unit_comp(vy, len);
      g.dir_z = unit_comp(vz, len);
      g.dir_valid = 1'b1;
    end else begin
      g.dir_x = '0;
      g.dir_y = '0;
      g.dir_z = '0;
      g.dir_valid = 1'b0;
    end
    return g;
  endfunction

  assign pending = geom_q.size();

  always @(posedge clk) begin
    geom_t e;
    if (rst) begin
      errors <= 0;
      checked <= 0;
    end else begin
      if (req.valid && req.ready)
        geom_q = {geom_q, predict_geometry(req.opcode, req.x0, req.y0, req.z0,
                                           req.x1, req.y1, req.z1, req.x2, req.y2, req.z2)};
      if (rsp.valid && rsp.ready) begin
        checked <= checked + 1;
        if (geom_q.size() == 0) begin
          $display("%0t: result word with nothing expected: measure %0d", $time, rsp.measure);
          errors <= errors + 1;
        end else begin
          e = geom_q.pop_front();
          if (e.measure !== rsp.measure || e.dir_x !== rsp.dir_x || e.dir_y !== rsp.dir_y ||
              e.dir_z !== rsp.dir_z || e.dir_valid !== rsp.dir_valid) begin
            $display("%0t: mismatch expected m=%0d d=(%0d,%0d,%0d) v=%0b", $time, e.measure,
                     e.dir_x, e.dir_y, e.dir_z, e.dir_valid);
            $display("%0t:            actual m=%0d d=(%0d,%0d,%0d) v=%0b", $time,
                     rsp.measure, rsp.dir_x, rsp.dir_y, rsp.dir_z, rsp.dir_valid);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb.sv
// Top of the mesh element geometry testbench: clock, reset, stimulus, result backpressure
// and the verdict. Depends on meg_pkg, the channel interfaces and geometry_checker.
module tb import meg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1700;
  localparam int CALM_WORDS   = 200;
  localparam int STALL_LIMIT  = 3000;

  // The one opcode value that the block does not define.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk, rst;
  logic calm;
  int   errors, pending, checked, idle_cycles, sent;

  meg_in_if  req();
  meg_out_if rsp();

  mesh_element_geometry DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  geometry_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                          .errors(errors), .pending(pending), .checked(checked));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: stalls in bursts until the final calm stretch.
  initial begin
    rsp.ready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        rsp.ready <= 1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL mesh_element_geometry");
        $finish;
      end
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic signed [FIELD_W-1:0] x0, y0, z0,
                           x1, y1, z1, x2, y2, z2);
    @(negedge clk);
    req.valid <= 1; req.opcode <= op;
    req.x0 <= x0; req.y0 <= y0; req.z0 <= z0;
    req.x1 <= x1; req.y1 <= y1; req.z1 <= z1;
    req.x2 <= x2; req.y2 <= y2; req.z2 <= z2;
    do @(posedge clk); while (!req.ready);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      req.valid <= 0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
  endtask

  // Coordinates: full range, small around a random base, or an extreme.
  function automatic logic signed [FIELD_W-1:0] pick_coord(int kind, int base);
    case (kind)
      0: return FIELD_W'($urandom);
      1: return FIELD_W'(base + $signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  localparam logic signed [FIELD_W-1:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_W-1:0] NMAX = 24'sh800000;

  initial begin
    int kind, base;
    logic [OP_W-1:0] op;
    logic signed [FIELD_W-1:0] c[9];
    calm = 0; sent = 0;
    req.valid = 0; req.opcode = '0;
    {req.x0, req.y0, req.z0, req.x1, req.y1, req.z1, req.x2, req.y2, req.z2} = '0;
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 0;

    // Directed: zero lengths, unit axes where the quotient saturates, extremes, opcode 3.
    send_word(OP_EDGE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EDGE, 1, 0, 0, 0, 0, 0, 5, 5, 5);
    send_word(OP_EDGE, 0, -1, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EDGE, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    send_word(OP_EDGE, 3, 4, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EDGE, PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, 0, 0, 0);
    send_word(OP_EDGE, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, 0, 0, 0);
    send_word(OP_EDGE, 1, 1, 1, 0, 0, 0, 0, 0, 0);
    send_word(OP_SEGMENT, 0, 0, PMAX, 0, 0, NMAX, 1, 2, 3);
    send_word(OP_SEGMENT, PMAX, NMAX, 0, NMAX, PMAX, 0, 0, 0, 0);
    send_word(OP_SEGMENT, 3, 4, 7, 0, 0, -9, PMAX, NMAX, PMAX);
    send_word(OP_TRIANGLE, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_word(OP_TRIANGLE, 0, 0, 0, 0, 1, 0, 1, 0, 0);
    send_word(OP_TRIANGLE, 0, 0, 0, 1, 1, 1, 2, 2, 2);
    send_word(OP_TRIANGLE, 5, 5, 5, 5, 5, 5, 5, 5, 5);
    send_word(OP_TRIANGLE, NMAX, NMAX, NMAX, PMAX, NMAX, NMAX, NMAX, PMAX, NMAX);
    send_word(OP_TRIANGLE, NMAX, NMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, PMAX);
    send_word(OP_TRIANGLE, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, PMAX, NMAX);
    send_word(OP_TRIANGLE, 0, 0, 0, 1, 2, 3, 4, 5, 7);
    send_word(OP_UNUSED, PMAX, NMAX, 1, 2, 3, 4, 5, 6, 7);
    send_word(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_WORDS) calm = 1;
      op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
      kind = $urandom_range(0, 9);
      kind = kind < 5 ? 0 : (kind < 9 ? 1 : 2);
      base = $signed($urandom);
      base = base >>> 8;
      foreach (c[j]) c[j] = pick_coord(kind, base);
      send_word(op, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
    end
    @(negedge clk) req.valid <= 0;
    calm = 1;

    wait (pending == 0);
    repeat (150) @(posedge clk);
    $display("Sent %0d words (edges, segments, triangles, unused opcode), checked %0d results",
             sent, checked);
    $display("under random source gaps and sink stalls, with errors %0d", errors);
    if (errors == 0 && pending == 0)
      $display("PASS mesh_element_geometry");
    else
      $display("FAIL mesh_element_geometry");
    $finish;
  end
endmodule

>>> filelist.f
src/meg_pkg.sv
src/meg_in_if.sv
src/meg_out_if.sv
src/meg_front.sv
src/meg_sqrt_cell.sv
src/meg_div_cell.sv
src/mesh_element_geometry.sv
verif/geometry_checker.sv
verif/tb.sv
